// ===== design/pinhole_ray_direction_defines.svh =====
// Assertion macros for the ray direction block.
// Both expect clk and rst_n in the scope of use.
`ifndef PINHOLE_RAY_DIRECTION_DEFINES_SVH
`define PINHOLE_RAY_DIRECTION_DEFINES_SVH

// Same-cycle implication.
`define PRD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PRD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/prd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package prd_pkg;

    localparam int PIX_W     = 20;
    localparam int DIR_W     = 16;
    localparam int REG_W     = 63;
    localparam int NUM_REGS  = 7;
    localparam int APB_AW    = 6;
    localparam int APB_DW    = 64;
    localparam int UNIT_FRAC = 30;
    localparam int MAG_BITS  = 30;

    localparam int DEF_COORD_FRAC_BITS = 8;
    localparam int DEF_COEF_WIDTH      = 21;
    localparam int DEF_DIR_FRAC_BITS   = 14;

    typedef enum logic [2:0] {
        REG_CAM_ROW_X = 3'd0,
        REG_CAM_ROW_Y = 3'd1,
        REG_CAM_ROW_Z = 3'd2,
        REG_CAM_ROW_W = 3'd3,
        REG_ROT_ROW_0 = 3'd4,
        REG_ROT_ROW_1 = 3'd5,
        REG_ROT_ROW_2 = 3'd6
    } reg_idx_t;

    // Matrix rows as held by the register bank
    typedef struct packed {
        logic [3:0][REG_W-1:0] cam;
        logic [2:0][REG_W-1:0] rot;
    } cfg_t;

endpackage

`default_nettype wire

// ===== design/prd_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module prd_cfg
    import prd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[APB_AW-1:3]);
    assign wr     = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr)
        begin
            case (idx)
                REG_CAM_ROW_X: cfg_reg.cam[0] <= pwdata[REG_W-1:0];
                REG_CAM_ROW_Y: cfg_reg.cam[1] <= pwdata[REG_W-1:0];
                REG_CAM_ROW_Z: cfg_reg.cam[2] <= pwdata[REG_W-1:0];
                REG_CAM_ROW_W: cfg_reg.cam[3] <= pwdata[REG_W-1:0];
                REG_ROT_ROW_0: cfg_reg.rot[0] <= pwdata[REG_W-1:0];
                REG_ROT_ROW_1: cfg_reg.rot[1] <= pwdata[REG_W-1:0];
                REG_ROT_ROW_2: cfg_reg.rot[2] <= pwdata[REG_W-1:0];
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_CAM_ROW_X: prdata = APB_DW'(cfg_reg.cam[0]);
            REG_CAM_ROW_Y: prdata = APB_DW'(cfg_reg.cam[1]);
            REG_CAM_ROW_Z: prdata = APB_DW'(cfg_reg.cam[2]);
            REG_CAM_ROW_W: prdata = APB_DW'(cfg_reg.cam[3]);
            REG_ROT_ROW_0: prdata = APB_DW'(cfg_reg.rot[0]);
            REG_ROT_ROW_1: prdata = APB_DW'(cfg_reg.rot[1]);
            REG_ROT_ROW_2: prdata = APB_DW'(cfg_reg.rot[2]);
            default:       prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/prd_project.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Raster to camera: products, row sums, then fold the sign of w in.
module prd_project
    import prd_pkg::*;
#(
    parameter int CF = DEF_COORD_FRAC_BITS,
    parameter int CW = DEF_COEF_WIDTH,
    parameter int VW = DEF_COEF_WIDTH + PIX_W + 3
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [PIX_W-1:0]      x,
    input  logic [PIX_W-1:0]      y,
    input  logic [3:0][REG_W-1:0] cam,
    output logic                  out_valid,
    output logic                  out_ok,
    output logic [2:0][VW-1:0]    out_v
);

    localparam int PW = CW + PIX_W + 1;

    logic                  p1_valid_reg, p2_valid_reg, p3_valid_reg;
    logic [3:0][PW-1:0]    px_reg, py_reg, pc_reg;
    logic [3:0][PW-1:0]    px_next, py_next, pc_next;
    logic [3:0][VW-1:0]    sum_reg, sum_next;
    logic                  ok_reg;
    logic [2:0][VW-1:0]    v_reg, v_next;

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            px_next[r] = $signed(cam[r][0*CW +: CW]) * $signed({1'b0, x});
            py_next[r] = $signed(cam[r][1*CW +: CW]) * $signed({1'b0, y});
            pc_next[r] = PW'($signed(cam[r][2*CW +: CW])) <<< CF;
        end
    end

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            sum_next[r] = VW'($signed(px_reg[r])) + VW'($signed(py_reg[r]))
                        + VW'($signed(pc_reg[r]));
        end
        for (int r = 0; r < 3; r++)
        begin
            v_next[r] = sum_reg[3][VW-1] ? (~sum_reg[r] + VW'(1)) : sum_reg[r];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_valid_reg <= in_valid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg  <= px_next;
            py_reg  <= py_next;
            pc_reg  <= pc_next;
            sum_reg <= sum_next;
            ok_reg  <= |sum_reg[3];
            v_reg   <= v_next;
        end
    end

    assign out_valid = p3_valid_reg;
    assign out_ok    = ok_reg;
    assign out_v     = v_reg;

endmodule

`default_nettype wire

// ===== design/prd_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Vector normaliser: abs, max, scale to 30 bits, squares, sum,
// one square-root step per stage, then one quotient bit per stage.
module prd_unit
    import prd_pkg::*;
#(
    parameter int VW   = DEF_COEF_WIDTH + PIX_W + 3,
    parameter int FRAC = UNIT_FRAC
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic                  in_ok,
    input  logic [2:0][VW-1:0]    in_v,
    output logic                  out_valid,
    output logic                  out_ok,
    output logic [2:0][FRAC+1:0]  out_q
);

    localparam int AW    = MAG_BITS;
    localparam int SW    = 2 * AW + 2;
    localparam int RW    = AW + 1;
    localparam int RES_W = SW + 1;
    localparam int SQN   = AW + 1;
    localparam int QB    = FRAC + 1;
    localparam int NW    = AW + FRAC + 1;
    localparam int QW    = FRAC + 2;
    localparam int KW    = $clog2(VW - AW + 1);

    typedef struct packed {
        logic                 ok;
        logic [2:0]           neg;
        logic [2:0][AW-1:0]   a;
        logic [RES_W-1:0]     rem;
        logic [RES_W-1:0]     res;
    } sq_t;

    typedef struct packed {
        logic                 ok;
        logic [2:0]           neg;
        logic [RW-1:0]        r;
        logic [2:0][NW-1:0]   num;
        logic [2:0][RW-1:0]   rem;
        logic [2:0][QB-1:0]   q;
    } dv_t;

    // front stages
    logic                  s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                  s4_valid_reg, s5_valid_reg;
    logic                  s1_ok_reg, s2_ok_reg, s3_ok_reg, s4_ok_reg, s5_ok_reg;
    logic [2:0]            s1_neg_reg, s2_neg_reg, s3_neg_reg, s4_neg_reg, s5_neg_reg;
    logic [2:0][VW-1:0]    s1_mag_reg, s2_mag_reg, mag_next;
    logic [VW-1:0]         s2_mx_reg, mx_next, m01;
    logic [2:0][AW-1:0]    s3_a_reg, s4_a_reg, s5_a_reg, a_next;
    logic [2:0][2*AW-1:0]  s4_sq_reg, sq_next;
    logic [SW-1:0]         s5_s_reg;
    logic                  nz;
    logic [KW-1:0]         k;

    always_comb
    begin
        nz = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            mag_next[i] = in_v[i][VW-1] ? (~in_v[i] + VW'(1)) : in_v[i];
            nz          = nz | (|in_v[i]);
        end
    end

    always_comb
    begin
        m01     = (s1_mag_reg[0] > s1_mag_reg[1]) ? s1_mag_reg[0] : s1_mag_reg[1];
        mx_next = (m01 > s1_mag_reg[2]) ? m01 : s1_mag_reg[2];
    end

    // shift that brings the largest magnitude under 2^AW
    always_comb
    begin
        k = '0;
        for (int b = AW; b < VW; b++)
        begin
            if (s2_mx_reg[b])
            begin
                k = KW'(b - AW + 1);
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            a_next[i] = AW'(s2_mag_reg[i] >> k);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_next[i] = (2 * AW)'(s3_a_reg[i]) * (2 * AW)'(s3_a_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ok_reg  <= in_ok && nz;
            s1_neg_reg <= {in_v[2][VW-1], in_v[1][VW-1], in_v[0][VW-1]};
            s1_mag_reg <= mag_next;
            s2_ok_reg  <= s1_ok_reg;
            s2_neg_reg <= s1_neg_reg;
            s2_mag_reg <= s1_mag_reg;
            s2_mx_reg  <= mx_next;
            s3_ok_reg  <= s2_ok_reg;
            s3_neg_reg <= s2_neg_reg;
            s3_a_reg   <= a_next;
            s4_ok_reg  <= s3_ok_reg;
            s4_neg_reg <= s3_neg_reg;
            s4_a_reg   <= s3_a_reg;
            s4_sq_reg  <= sq_next;
            s5_ok_reg  <= s4_ok_reg;
            s5_neg_reg <= s4_neg_reg;
            s5_a_reg   <= s4_a_reg;
            s5_s_reg   <= SW'(s4_sq_reg[0]) + SW'(s4_sq_reg[1]) + SW'(s4_sq_reg[2]);
        end
    end

    // square root, one result bit per stage
    sq_t  sq_d   [SQN+1];
    logic sqv_d  [SQN+1];
    sq_t  sq_reg [SQN];
    logic sqv_reg[SQN];

    assign sq_d[0]  = {s5_ok_reg, s5_neg_reg, s5_a_reg, RES_W'(s5_s_reg), RES_W'(0)};
    assign sqv_d[0] = s5_valid_reg;

    for (genvar g = 0; g < SQN; g++)
    begin : g_sqrt
        localparam logic [RES_W-1:0] BITV = RES_W'(1) << (2 * (AW - g));
        sq_t              sq_next;
        logic [RES_W-1:0] trial;

        always_comb
        begin
            sq_next = sq_d[g];
            trial   = sq_d[g].res + BITV;
            if (sq_d[g].rem >= trial)
            begin
                sq_next.rem = sq_d[g].rem - trial;
                sq_next.res = (sq_d[g].res >> 1) + BITV;
            end
            else
            begin
                sq_next.res = sq_d[g].res >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sqv_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                sqv_reg[g] <= sqv_d[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_reg[g] <= sq_next;
            end
        end

        assign sq_d[g+1]  = sq_reg[g];
        assign sqv_d[g+1] = sqv_reg[g];
    end

    // divider set-up: rounded numerator, top part already below r
    dv_t  dv0_reg, dv0_next;
    logic dv0_valid_reg;

    always_comb
    begin
        dv0_next.ok  = sq_d[SQN].ok;
        dv0_next.neg = sq_d[SQN].neg;
        dv0_next.r   = sq_d[SQN].res[RW-1:0];
        dv0_next.q   = '0;
        for (int i = 0; i < 3; i++)
        begin
            dv0_next.num[i] = (NW'(sq_d[SQN].a[i]) << FRAC)
                            + NW'(sq_d[SQN].res[RW-1:1]);
            dv0_next.rem[i] = RW'(dv0_next.num[i] >> QB);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv0_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            dv0_valid_reg <= sqv_d[SQN];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv0_reg <= dv0_next;
        end
    end

    dv_t  dv_d   [QB+1];
    logic dvv_d  [QB+1];
    dv_t  dv_reg [QB];
    logic dvv_reg[QB];

    assign dv_d[0]  = dv0_reg;
    assign dvv_d[0] = dv0_valid_reg;

    for (genvar g = 0; g < QB; g++)
    begin : g_div
        localparam int J = QB - 1 - g;
        dv_t             dv_next;
        logic [2:0][RW:0] rem2;

        always_comb
        begin
            dv_next = dv_d[g];
            for (int i = 0; i < 3; i++)
            begin
                rem2[i] = {dv_d[g].rem[i], dv_d[g].num[i][J]};
                if (rem2[i] >= {1'b0, dv_d[g].r})
                begin
                    dv_next.rem[i]  = RW'(rem2[i] - {1'b0, dv_d[g].r});
                    dv_next.q[i][J] = 1'b1;
                end
                else
                begin
                    dv_next.rem[i] = rem2[i][RW-1:0];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dvv_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                dvv_reg[g] <= dvv_d[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_reg[g] <= dv_next;
            end
        end

        assign dv_d[g+1]  = dv_reg[g];
        assign dvv_d[g+1] = dvv_reg[g];
    end

    // sign back on
    logic                 o_valid_reg, o_ok_reg;
    logic [2:0][QW-1:0]   o_q_reg, o_q_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            o_q_next[i] = dv_d[QB].neg[i] ? (QW'(0) - QW'(dv_d[QB].q[i]))
                                          : QW'(dv_d[QB].q[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            o_valid_reg <= dvv_d[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_ok_reg <= dv_d[QB].ok;
            o_q_reg  <= o_q_next;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_ok    = o_ok_reg;
    assign out_q     = o_q_reg;

endmodule

`default_nettype wire

// ===== design/prd_rotate.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Camera to world rotation: nine products, then three row sums.
module prd_rotate
    import prd_pkg::*;
#(
    parameter int CW = DEF_COEF_WIDTH,
    parameter int UW = UNIT_FRAC + 2
)(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic                    in_ok,
    input  logic [2:0][UW-1:0]      in_u,
    input  logic [2:0][REG_W-1:0]   rot,
    output logic                    out_valid,
    output logic                    out_ok,
    output logic [2:0][CW+UW+1:0]   out_v
);

    localparam int PW = CW + UW;
    localparam int VW = PW + 2;

    logic                     r1_valid_reg, r2_valid_reg;
    logic                     r1_ok_reg, r2_ok_reg;
    logic [2:0][2:0][PW-1:0]  prod_reg, prod_next;
    logic [2:0][VW-1:0]       v_reg, v_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                prod_next[i][j] = $signed(rot[i][j*CW +: CW]) * $signed(in_u[j]);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            v_next[i] = VW'($signed(prod_reg[i][0])) + VW'($signed(prod_reg[i][1]))
                      + VW'($signed(prod_reg[i][2]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_valid_reg <= 1'b0;
            r2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            r1_valid_reg <= in_valid;
            r2_valid_reg <= r1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_ok_reg <= in_ok;
            prod_reg  <= prod_next;
            r2_ok_reg <= r1_ok_reg;
            v_reg     <= v_next;
        end
    end

    assign out_valid = r2_valid_reg;
    assign out_ok    = r2_ok_reg;
    assign out_v     = v_reg;

endmodule

`default_nettype wire

// ===== design/pinhole_ray_direction.sv =====
// Throughput: one word per cycle while the skid word is empty; each normaliser
//   takes one square-root bit and one quotient bit per stage, so pipeline
//   depth grows with the fraction widths.
// Reset: rst_n clears all valid bits, the output/skid flags and the matrix
//   registers (zero matrices give degenerate words until programmed).
`timescale 1ns / 1ps
`default_nettype none

`include "pinhole_ray_direction_defines.svh"

module pinhole_ray_direction
    import prd_pkg::*;
#(
    parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS,
    parameter int COEF_WIDTH      = DEF_COEF_WIDTH,
    parameter int DIR_FRAC_BITS   = DEF_DIR_FRAC_BITS
)(
    input  logic              clk,
    input  logic              rst_n,
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    // raster points in
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [PIX_W-1:0]  pixel_x,
    input  logic [PIX_W-1:0]  pixel_y,
    // directions out
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DIR_W-1:0]  dir_x,
    output logic [DIR_W-1:0]  dir_y,
    output logic [DIR_W-1:0]  dir_z,
    output logic              degenerate
);

    localparam int CAM_W = COEF_WIDTH + PIX_W + 3;   // x, y, z, w before the sign fold
    localparam int CU_W  = UNIT_FRAC + 2;            // camera unit vector, Q1.30
    localparam int ROT_W = COEF_WIDTH + CU_W + 2;    // rotated vector
    localparam int DQ_W  = DIR_FRAC_BITS + 2;

    typedef struct packed {
        logic [DIR_W-1:0] dx;
        logic [DIR_W-1:0] dy;
        logic [DIR_W-1:0] dz;
        logic             degen;
    } res_t;

    cfg_t cfg;

    // The whole pipeline moves together; it halts only while the skid
    // word is occupied, so an output stall costs nothing until two words queue.
    logic adv;

    logic                    pj_valid, pj_ok;
    logic [2:0][CAM_W-1:0]   pj_v;
    logic                    u1_valid, u1_ok;
    logic [2:0][CU_W-1:0]    u1_q;
    logic                    rt_valid, rt_ok;
    logic [2:0][ROT_W-1:0]   rt_v;
    logic                    u2_valid, u2_ok;
    logic [2:0][DQ_W-1:0]    u2_q;

    prd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    prd_project #(
        .CF (COORD_FRAC_BITS),
        .CW (COEF_WIDTH),
        .VW (CAM_W)
    ) u_project (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (in_valid),
        .x         (pixel_x),
        .y         (pixel_y),
        .cam       (cfg.cam),
        .out_valid (pj_valid),
        .out_ok    (pj_ok),
        .out_v     (pj_v)
    );

    prd_unit #(
        .VW   (CAM_W),
        .FRAC (UNIT_FRAC)
    ) u_unit_cam (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (pj_valid),
        .in_ok     (pj_ok),
        .in_v      (pj_v),
        .out_valid (u1_valid),
        .out_ok    (u1_ok),
        .out_q     (u1_q)
    );

    prd_rotate #(
        .CW (COEF_WIDTH),
        .UW (CU_W)
    ) u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (u1_valid),
        .in_ok     (u1_ok),
        .in_u      (u1_q),
        .rot       (cfg.rot),
        .out_valid (rt_valid),
        .out_ok    (rt_ok),
        .out_v     (rt_v)
    );

    prd_unit #(
        .VW   (ROT_W),
        .FRAC (DIR_FRAC_BITS)
    ) u_unit_dir (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (rt_valid),
        .in_ok     (rt_ok),
        .in_v      (rt_v),
        .out_valid (u2_valid),
        .out_ok    (u2_ok),
        .out_q     (u2_q)
    );

    // Final word: zero direction when degenerate, otherwise Q1.F cut to 16 bits
    res_t pipe_res;

    assign pipe_res.dx    = u2_ok ? DIR_W'($signed(u2_q[0])) : '0;
    assign pipe_res.dy    = u2_ok ? DIR_W'($signed(u2_q[1])) : '0;
    assign pipe_res.dz    = u2_ok ? DIR_W'($signed(u2_q[2])) : '0;
    assign pipe_res.degen = !u2_ok;

    // Output register plus one skid word
    logic out_valid_reg, out_valid_next;
    logic skid_full_reg, skid_full_next;
    res_t out_reg, skid_reg;
    logic take, load_pipe, load_skid, load_from_skid;

    assign take     = out_valid_reg && !out_stall;
    assign adv      = !skid_full_reg;
    assign in_stall = skid_full_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        skid_full_next = skid_full_reg;
        load_pipe      = 1'b0;
        load_skid      = 1'b0;
        load_from_skid = 1'b0;
        if (skid_full_reg)
        begin
            if (take)
            begin
                load_from_skid = 1'b1;
                skid_full_next = 1'b0;
            end
        end
        else if (!out_valid_reg || take)
        begin
            out_valid_next = u2_valid;
            load_pipe      = u2_valid;
        end
        else if (u2_valid)
        begin
            load_skid      = 1'b1;
            skid_full_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_from_skid)
        begin
            out_reg <= skid_reg;
        end
        else if (load_pipe)
        begin
            out_reg <= pipe_res;
        end
        if (load_skid)
        begin
            skid_reg <= pipe_res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign dir_x      = out_reg.dx;
    assign dir_y      = out_reg.dy;
    assign dir_z      = out_reg.dz;
    assign degenerate = out_reg.degen;

    // skid word only ever sits behind a held output word
    `PRD_ASSERT_IMP(a_skid_behind_out, skid_full_reg, out_valid_reg,
        "skid word held without an output word")
    // a held skid word stays until the output moves
    `PRD_ASSERT_NXT(a_skid_holds, skid_full_reg && out_stall, skid_full_reg,
        "skid word dropped while output stalled")
    // degenerate words carry a zero direction
    `PRD_ASSERT_IMP(a_degen_zero, out_valid_reg && out_reg.degen,
        out_reg.dx == '0 && out_reg.dy == '0 && out_reg.dz == '0,
        "degenerate word with non-zero direction")

endmodule

`default_nettype wire
